@@ hdl/command_frame_receiver_macros.svh @@
// ----------------------------------------------------------------------------
// command_frame_receiver_macros
// Assertion macros for the command frame receiver; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef COMMAND_FRAME_RECEIVER_MACROS_SVH
`define COMMAND_FRAME_RECEIVER_MACROS_SVH

`ifndef SYNTHESIS
// Implication within the same cycle.
`define CFR_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication in the next cycle.
`define CFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFR_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define CFR_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ hdl/cfr_pkg.sv @@
// ----------------------------------------------------------------------------
// cfr_pkg
// Types, codes and constants of the command frame receiver.
// ----------------------------------------------------------------------------
package cfr_pkg;

  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned POS_W     = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PREFIX  = 1'b0,
    CFG_WAKEUP_PREFIX = 1'b1
  } cfr_cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_ADDR  = 3'd1,
    ST_CMD   = 3'd2,
    ST_BOOT  = 3'd3,
    ST_START = 3'd4,
    ST_READ  = 3'd5,
    ST_WRITE = 3'd6,
    ST_CKS   = 3'd7
  } cfr_state_e;

  typedef enum logic [2:0] {
    EV_BUSY  = 3'd0,
    EV_TIME  = 3'd1,
    EV_DATA  = 3'd2,
    EV_OK    = 3'd3,
    EV_CKERR = 3'd4,
    EV_ABORT = 3'd5
  } cfr_event_e;

  localparam logic [7:0] ADDR_BYTE      = 8'hFF;
  localparam logic [7:0] WAKEUP_SEED    = 8'hFF;
  localparam logic [7:0] CMD_CTRL0      = 8'h00;
  localparam logic [7:0] CMD_CTRL1      = 8'h01;
  localparam logic [7:0] CMD_CTRL2      = 8'h02;
  localparam logic [7:0] CMD_CTRL6      = 8'h06;
  localparam logic [7:0] CMD_READ       = 8'h03;
  localparam logic [7:0] CMD_READ_B     = 8'h0B;
  localparam logic [7:0] CMD_READ_E     = 8'h0E;
  localparam logic [7:0] CMD_WRITE      = 8'h04;
  localparam logic [7:0] CMD_START_TIME = 8'h0A;
  localparam logic [7:0] CMD_BOOT       = 8'h09;

  localparam logic [POS_W-1:0] BOOT_KEY_LEN = 9'd5;
  localparam logic [POS_W-1:0] HDR_BYTES    = 9'd3;
  localparam logic [POS_W-1:0] HDR_LEN      = 9'd4;

  // Boot key, one byte per position.
  function automatic logic [7:0] boot_key(input logic [2:0] idx);
    logic [7:0] key;
    case (idx)
      3'd0:    key = 8'h66;
      3'd1:    key = 8'h99;
      3'd2:    key = 8'h55;
      3'd3:    key = 8'hFF;
      default: key = 8'h00;
    endcase
    return key;
  endfunction

  // Parser state that follows a command byte; idle for unknown codes.
  function automatic cfr_state_e cmd_next_state(input logic [7:0] cmd);
    cfr_state_e nxt;
    case (cmd) inside
      CMD_CTRL0, CMD_CTRL1, CMD_CTRL2, CMD_CTRL6: nxt = ST_CKS;
      CMD_READ, CMD_READ_B, CMD_READ_E:          nxt = ST_READ;
      CMD_WRITE:                                 nxt = ST_WRITE;
      CMD_START_TIME:                            nxt = ST_START;
      CMD_BOOT:                                  nxt = ST_BOOT;
      default:                                   nxt = ST_IDLE;
    endcase
    return nxt;
  endfunction

endpackage

@@ hdl/cfr_rx_if.sv @@
// ----------------------------------------------------------------------------
// cfr_rx_if
// Received byte channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfr_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hdl/cfr_res_if.sv @@
// ----------------------------------------------------------------------------
// cfr_res_if
// Decode event channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cfr_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  command;
  logic [23:0] mem_addr;
  logic [7:0]  byte_count;
  logic [7:0]  data_byte;
  logic [7:0]  data_index;

  modport source (
    output valid, output event_res, output command, output mem_addr,
    output byte_count, output data_byte, output data_index, input ready
  );
  modport sink (
    input valid, input event_res, input command, input mem_addr,
    input byte_count, input data_byte, input data_index, output ready
  );
endinterface

@@ hdl/command_frame_receiver.sv @@
// ----------------------------------------------------------------------------
// command_frame_receiver
// Byte-wise decoder of prefixed, checksummed command frames.
// ----------------------------------------------------------------------------
// Usage:
//   rx_i carries one received byte per request. Each byte gives exactly one
//   request on res_o: an event code (busy, start-time byte, write-data byte,
//   accepted, checksum error, aborted) plus the command, 24-bit address and
//   count of the current frame and, for payload events, the byte and index.
//   A checksum error means the host should reply 0xEE.
//   cfg_we_i/cfg_idx_i/cfg_wdata_i set the start and wake-up prefixes; write
//   them only while no byte is in flight.
//   An event is registered; it appears in the cycle after its byte is taken.
//   Throughput: one byte per cycle unless res_o stalls; the parser state
//   update and result register are a single step: back-to-back bytes have no gaps.
//   Reset clears the parser to idle, all frame fields and both prefixes to
//   zero and empties the result register.
//   When the receiver of res_o stalls, the result register holds its event
//   and rx_i.ready drops until it is taken; one accepted byte in the same
//   cycle as the taking refills it.
// ----------------------------------------------------------------------------
`include "command_frame_receiver_macros.svh"

module command_frame_receiver #(
  parameter int unsigned START_TIME_BYTES = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfr_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_wdata_i,
  cfr_rx_if.sink                        rx_i,
  cfr_res_if.source                     res_o
);
  import cfr_pkg::*;

  localparam logic [POS_W-1:0] StartLen = POS_W'(START_TIME_BYTES);

  // Configuration.
  logic [7:0] start_prefix_q, wakeup_prefix_q;

  // Parser state.
  cfr_state_e       state_q, state_d;
  logic [7:0]       sum_q, sum_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [23:0]      addr_q, addr_d;
  logic [7:0]       count_q, count_d;

  // Result register.
  logic       res_valid_q, res_valid_d;
  cfr_event_e ev_q, ev_d;
  logic [7:0] dbyte_q, dbyte_d;
  logic [7:0] didx_q, didx_d;

  logic             rx_fire;
  logic [7:0]       b;
  logic [POS_W-1:0] pos_inc;
  logic [7:0]       sum_add;
  cfr_state_e       cmd_state;
  logic             key_ok;
  logic             cks_ok;

  // Take a new byte whenever the result register is empty or draining.
  assign rx_i.ready = !res_valid_q || res_o.ready;
  assign rx_fire    = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;

  assign pos_inc   = pos_q + POS_W'(1);
  assign sum_add   = sum_q + b;
  assign cmd_state = cmd_next_state(b);
  assign key_ok    = (pos_q < BOOT_KEY_LEN) && (b == boot_key(pos_q[2:0]));
  assign cks_ok    = (b == 8'(8'd0 - sum_q));

  // Next parser state.
  always_comb begin
    state_d = state_q;
    if (rx_fire) begin
      case (state_q)
        ST_IDLE: begin
          // start prefix wins when both prefixes match
          if (b == start_prefix_q) begin
            state_d = ST_ADDR;
          end else if (b == wakeup_prefix_q) begin
            state_d = ST_CMD;
          end else begin
            state_d = ST_IDLE;
          end
        end
        ST_ADDR:  state_d = (b == ADDR_BYTE) ? ST_CMD : ST_IDLE;
        ST_CMD:   state_d = cmd_state;
        ST_BOOT: begin
          if (!key_ok) begin
            state_d = ST_IDLE;
          end else if (pos_q == BOOT_KEY_LEN - POS_W'(1)) begin
            state_d = ST_CKS;
          end
        end
        ST_START: begin
          if (pos_inc >= StartLen) begin
            state_d = ST_CKS;
          end
        end
        ST_READ: begin
          if (pos_q >= HDR_BYTES) begin
            state_d = ST_CKS;
          end
        end
        ST_WRITE: begin
          // count_d already holds the count byte when it arrives now
          if (pos_inc >= ({1'b0, count_d} + HDR_LEN)) begin
            state_d = ST_CKS;
          end
        end
        default: state_d = ST_IDLE;
      endcase
    end
  end

  // Frame fields and result for the accepted byte.
  always_comb begin
    sum_d   = sum_q;
    pos_d   = pos_q;
    cmd_d   = cmd_q;
    addr_d  = addr_q;
    count_d = count_q;
    ev_d    = EV_BUSY;
    dbyte_d = 8'd0;
    didx_d  = 8'd0;
    if (rx_fire) begin
      case (state_q)
        ST_IDLE: begin
          pos_d = '0;
          cmd_d = 8'd0;
          if (b == start_prefix_q) begin
            sum_d = 8'd0;
          end else if (b == wakeup_prefix_q) begin
            // wake-up frames skip the address byte; seed its sum
            sum_d = WAKEUP_SEED;
          end else begin
            sum_d = 8'd0;
            ev_d  = EV_ABORT;
          end
        end
        ST_ADDR: begin
          if (b == ADDR_BYTE) begin
            sum_d = sum_add;
          end else begin
            sum_d = 8'd0;
            ev_d  = EV_ABORT;
          end
        end
        ST_CMD: begin
          cmd_d = b;
          if (cmd_state == ST_IDLE) begin
            sum_d = 8'd0;
            ev_d  = EV_ABORT;
          end else begin
            sum_d = sum_add;
          end
        end
        ST_BOOT: begin
          if (key_ok) begin
            sum_d = sum_add;
            if (pos_q != BOOT_KEY_LEN - POS_W'(1)) begin
              pos_d = pos_inc;
            end
          end else begin
            sum_d = 8'd0;
            ev_d  = EV_ABORT;
          end
        end
        ST_START: begin
          sum_d   = sum_add;
          pos_d   = pos_inc;
          ev_d    = EV_TIME;
          dbyte_d = b;
          didx_d  = pos_q[7:0];
        end
        ST_READ: begin
          sum_d = sum_add;
          pos_d = pos_inc;
          if (pos_q < HDR_BYTES) begin
            addr_d = {addr_q[15:0], b};
          end else begin
            count_d = b;
          end
        end
        ST_WRITE: begin
          sum_d = sum_add;
          pos_d = pos_inc;
          if (pos_q < HDR_BYTES) begin
            addr_d = {addr_q[15:0], b};
          end else if (pos_q == HDR_BYTES) begin
            count_d = b;
          end else begin
            ev_d    = EV_DATA;
            dbyte_d = b;
            didx_d  = pos_q[7:0] - HDR_LEN[7:0];
          end
        end
        default: begin
          // checksum byte closes the frame either way
          sum_d = 8'd0;
          ev_d  = cks_ok ? EV_OK : EV_CKERR;
        end
      endcase
    end
  end

  assign res_valid_d = rx_fire || (res_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_prefix_q  <= 8'd0;
      wakeup_prefix_q <= 8'd0;
    end else if (cfg_we_i) begin
      case (cfr_cfg_idx_e'(cfg_idx_i))
        CFG_START_PREFIX:  start_prefix_q  <= cfg_wdata_i;
        CFG_WAKEUP_PREFIX: wakeup_prefix_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      sum_q       <= 8'd0;
      pos_q       <= '0;
      cmd_q       <= 8'd0;
      addr_q      <= 24'd0;
      count_q     <= 8'd0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sum_q       <= sum_d;
      pos_q       <= pos_d;
      cmd_q       <= cmd_d;
      addr_q      <= addr_d;
      count_q     <= count_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Payload of the result register; load on every accepted byte.
  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      ev_q    <= ev_d;
      dbyte_q <= dbyte_d;
      didx_q  <= didx_d;
    end
  end

  assign res_o.valid      = res_valid_q;
  assign res_o.event_res  = ev_q;
  // frame fields are only updated on accepts, so they match the held event
  assign res_o.command    = cmd_q;
  assign res_o.mem_addr   = addr_q;
  assign res_o.byte_count = count_q;
  assign res_o.data_byte  = dbyte_q;
  assign res_o.data_index = didx_q;

  `CFR_ASSERT_NEXT(a_cks_to_idle, clk_i, rst_ni, rx_fire && (state_q == ST_CKS), state_q == ST_IDLE)
  `CFR_ASSERT_NEXT(a_fire_gives_result, clk_i, rst_ni, rx_fire, res_valid_q)
  `CFR_ASSERT_NOW(a_idle_sum_clear, clk_i, rst_ni, state_q == ST_IDLE, sum_q == 8'd0)
  `CFR_ASSERT_NOW(a_time_index_range, clk_i, rst_ni, res_valid_q && (ev_q == EV_TIME), {1'b0, didx_q} < StartLen)

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the command frame receiver.
// ----------------------------------------------------------------------------
// Each received byte gives exactly one event request. A local frame decoder
// runs alongside the block and predicts every event. A short directed table
// is walked first: prefixes after reset, address and checksum extremes, and
// the abort and checksum-error paths. Random frames follow under several
// prefix settings, with random stalls on both channels, one long hold-off
// of the event channel, and a final phase with no idling.
// ----------------------------------------------------------------------------
module tb;
  import cfr_pkg::*;

  localparam int unsigned START_TIME_BYTES = 8;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned PHASE_ITEMS      = 255;
  localparam int unsigned NUM_PHASES       = 6;
  localparam int unsigned LONG_HOLD        = 80;
  localparam int unsigned SETTLE_CYCLES    = 3;
  localparam logic [39:0] BOOT_SEQ         = 40'h66_99_55_FF_00;
  localparam logic [79:0] KNOWN_CMDS       = {CMD_CTRL0, CMD_CTRL1, CMD_CTRL2, CMD_CTRL6,
                                              CMD_READ, CMD_READ_B, CMD_READ_E, CMD_WRITE,
                                              CMD_START_TIME, CMD_BOOT};

  typedef struct packed {
    cfr_event_e  ev;
    logic [7:0]  cmd;
    logic [23:0] addr;
    logic [7:0]  cnt;
    logic [7:0]  dbyte;
    logic [7:0]  didx;
  } frame_event_t;

  typedef struct packed {
    bit         pinned;
    cfr_event_e ev;
  } event_pin_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct packed {
    row_kind_e    kind;
    bit           pinned;
    cfr_event_e   ev;
    cfr_cfg_idx_e idx;
    logic [7:0]   value;
  } stim_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [7:0]           cfg_wdata;

  cfr_rx_if  rx_if ();
  cfr_res_if res_if ();

  command_frame_receiver #(
    .START_TIME_BYTES(START_TIME_BYTES)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .rx_i       (rx_if),
    .res_o      (res_if)
  );

  // Decoder copy of the parser state and the prefix registers.
  cfr_state_e  parse_st;
  logic [7:0]  sum_acc;
  logic [8:0]  pos;
  logic [7:0]  cur_cmd;
  logic [23:0] cur_addr;
  logic [7:0]  cur_cnt;
  logic [7:0]  start_pfx;
  logic [7:0]  wake_pfx;

  frame_event_t pending_events[$];
  event_pin_t   event_pins[$];
  stim_row_t    directed_rows[$];
  logic [7:0]   frame_bytes[$];
  logic [7:0]   frame_sum;
  int           err_count;
  bit           idling_on;
  bit           hold_results;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Advance the decoder by one byte and return the event it yields.
  function automatic frame_event_t decode_byte(input logic [7:0] b);
    frame_event_t r;
    r    = '0;
    r.ev = EV_BUSY;
    case (parse_st)
      ST_IDLE: begin
        sum_acc = '0;
        pos     = '0;
        cur_cmd = '0;
        // start prefix is checked first, so it wins when both are equal
        if (b == start_pfx) begin
          parse_st = ST_ADDR;
        end else if (b == wake_pfx) begin
          parse_st = ST_CMD;
          sum_acc  = WAKEUP_SEED;
        end else begin
          r.ev = EV_ABORT;
        end
      end
      ST_ADDR: begin
        if (b == ADDR_BYTE) begin
          sum_acc  = sum_acc + b;
          parse_st = ST_CMD;
        end else begin
          r.ev = EV_ABORT;
        end
      end
      ST_CMD: begin
        sum_acc = sum_acc + b;
        cur_cmd = b;
        case (b)
          CMD_CTRL0, CMD_CTRL1, CMD_CTRL2, CMD_CTRL6: parse_st = ST_CKS;
          CMD_READ, CMD_READ_B, CMD_READ_E:          parse_st = ST_READ;
          CMD_WRITE:                                 parse_st = ST_WRITE;
          CMD_START_TIME:                            parse_st = ST_START;
          CMD_BOOT:                                  parse_st = ST_BOOT;
          default:                                   r.ev = EV_ABORT;
        endcase
      end
      ST_BOOT: begin
        sum_acc = sum_acc + b;
        if (pos < 9'd5 && b == BOOT_SEQ[39 - 8*pos[2:0] -: 8]) begin
          if (pos == 9'd4) parse_st = ST_CKS;
          else pos = pos + 9'd1;
        end else begin
          r.ev = EV_ABORT;
        end
      end
      ST_START: begin
        sum_acc = sum_acc + b;
        r.ev    = EV_TIME;
        r.dbyte = b;
        r.didx  = pos[7:0];
        pos     = pos + 9'd1;
        if (pos >= START_TIME_BYTES) parse_st = ST_CKS;
      end
      ST_READ: begin
        sum_acc = sum_acc + b;
        if (pos < 9'd3) begin
          cur_addr = {cur_addr[15:0], b};
        end else begin
          cur_cnt  = b;
          parse_st = ST_CKS;
        end
        pos = pos + 9'd1;
      end
      ST_WRITE: begin
        sum_acc = sum_acc + b;
        if (pos < 9'd3) begin
          cur_addr = {cur_addr[15:0], b};
        end else if (pos == 9'd3) begin
          cur_cnt = b;
        end else begin
          r.ev    = EV_DATA;
          r.dbyte = b;
          r.didx  = 8'(pos - 9'd4);
        end
        pos = pos + 9'd1;
        // a zero count sends the parser straight to the checksum
        if (pos >= {1'b0, cur_cnt} + 9'd4) parse_st = ST_CKS;
      end
      default: begin
        if (b == 8'd0 - sum_acc) r.ev = EV_OK;
        else r.ev = EV_CKERR;
      end
    endcase
    if (r.ev inside {EV_ABORT, EV_OK, EV_CKERR}) begin
      parse_st = ST_IDLE;
      sum_acc  = '0;
    end
    r.cmd  = cur_cmd;
    r.addr = cur_addr;
    r.cnt  = cur_cnt;
    return r;
  endfunction

  task automatic compare_field(input string name, input logic [23:0] exp_v,
                               input logic [23:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      err_count++;
    end
  endtask

  // Predict on every accepted byte, check on every accepted event.
  always @(posedge clk) begin : event_monitor
    frame_event_t want;
    event_pin_t   pin;
    if (rst_n) begin
      if (rx_if.valid && rx_if.ready) begin
        want = decode_byte(rx_if.rx_byte);
        pin  = event_pins.pop_front();
        if (pin.pinned) want.ev = pin.ev;
        pending_events.push_back(want);
      end
      if (res_if.valid && res_if.ready) begin
        if (pending_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, actual %0h", $time,
                   res_if.event_res);
          err_count++;
        end else begin
          want = pending_events.pop_front();
          compare_field("event_res", 24'(want.ev), 24'(res_if.event_res));
          compare_field("command", 24'(want.cmd), 24'(res_if.command));
          compare_field("mem_addr", want.addr, res_if.mem_addr);
          compare_field("byte_count", 24'(want.cnt), 24'(res_if.byte_count));
          compare_field("data_byte", 24'(want.dbyte), 24'(res_if.data_byte));
          compare_field("data_index", 24'(want.didx), 24'(res_if.data_index));
        end
      end
    end
  end

  // Event receiver: random stall bursts, plus one long hold-off on request.
  initial begin : event_receiver
    int unsigned hold_cycles;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_results) begin
        res_if.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < LONG_HOLD) begin
          @(posedge clk);
          hold_cycles++;
        end
        hold_results = 1'b0;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic stim_row_t chk_byte(input logic [7:0] b, input cfr_event_e ev_code);
    return '{kind: ROW_BYTE, pinned: 1'b1, ev: ev_code, idx: CFG_START_PREFIX, value: b};
  endfunction

  function automatic stim_row_t any_byte(input logic [7:0] b);
    return '{kind: ROW_BYTE, pinned: 1'b0, ev: EV_BUSY, idx: CFG_START_PREFIX, value: b};
  endfunction

  function automatic stim_row_t cfg_row(input cfr_cfg_idx_e reg_idx, input logic [7:0] v);
    return '{kind: ROW_CFG, pinned: 1'b0, ev: EV_BUSY, idx: reg_idx, value: v};
  endfunction

  // Offer one byte, optionally after a random gap; return once it is taken.
  // Valid stays high afterwards so back-to-back bytes flow without a bubble.
  task automatic send_byte(input logic [7:0] b, input bit pin, input cfr_event_e pin_ev);
    event_pin_t p;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      rx_if.valid   <= 1'b0;
      rx_if.rx_byte <= 8'($urandom);
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    p.pinned = pin;
    p.ev     = pin_ev;
    event_pins.push_back(p);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  // Drop valid and hold until every expected event has come back.
  task automatic finish_stream();
    rx_if.valid <= 1'b0;
    @(posedge clk);
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfr_cfg_idx_e reg_idx, input logic [7:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= reg_idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (reg_idx == CFG_START_PREFIX) start_pfx = value;
    else wake_pfx = value;
    @(posedge clk);
  endtask

  task automatic add_frame_byte(input logic [7:0] b);
    frame_bytes.push_back(b);
    frame_sum = frame_sum + b;
  endtask

  // Build one frame with random content; now and then add leading noise,
  // an unknown command, a bad checksum or a corrupted byte.
  task automatic make_frame();
    logic [7:0] cmd;
    logic [7:0] cnt;
    frame_bytes.delete();
    if ($urandom_range(0, 9) == 0)
      repeat ($urandom_range(1, 3)) frame_bytes.push_back(8'($urandom));
    if (wake_pfx != start_pfx && $urandom_range(0, 3) == 0) begin
      frame_bytes.push_back(wake_pfx);
      frame_sum = WAKEUP_SEED;
    end else begin
      frame_bytes.push_back(start_pfx);
      frame_sum = '0;
      add_frame_byte(ADDR_BYTE);
    end
    if ($urandom_range(0, 19) == 0) cmd = 8'($urandom);
    else cmd = KNOWN_CMDS[8*$urandom_range(0, 9) +: 8];
    add_frame_byte(cmd);
    case (cmd)
      CMD_READ, CMD_READ_B, CMD_READ_E, CMD_WRITE: begin
        repeat (3) add_frame_byte(8'($urandom));
        // keep most write bursts short, a few reach the full count range
        if (cmd != CMD_WRITE || $urandom_range(0, 19) == 0) cnt = 8'($urandom);
        else cnt = 8'($urandom_range(0, 5));
        add_frame_byte(cnt);
        if (cmd == CMD_WRITE) repeat (cnt) add_frame_byte(8'($urandom));
      end
      CMD_START_TIME: repeat (START_TIME_BYTES) add_frame_byte(8'($urandom));
      CMD_BOOT: for (int k = 0; k < 5; k++) add_frame_byte(BOOT_SEQ[39 - 8*k -: 8]);
      default: ;
    endcase
    if ($urandom_range(0, 7) == 0)
      frame_bytes.push_back((8'd0 - frame_sum) ^ 8'($urandom_range(1, 255)));
    else
      frame_bytes.push_back(8'd0 - frame_sum);
    if ($urandom_range(0, 9) == 0)
      frame_bytes[$urandom_range(0, frame_bytes.size() - 1)] = 8'($urandom);
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    sent = 0;
    while (sent < n_items) begin
      make_frame();
      foreach (frame_bytes[k]) begin
        send_byte(frame_bytes[k], 1'b0, EV_BUSY);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] s_val;
    logic [7:0] w_val;
    clk           = 1'b0;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_idx       = CFG_START_PREFIX;
    cfg_wdata     = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    parse_st      = ST_IDLE;
    sum_acc       = '0;
    pos           = '0;
    cur_cmd       = '0;
    cur_addr      = '0;
    cur_cnt       = '0;
    start_pfx     = '0;
    wake_pfx      = '0;
    err_count     = 0;
    idling_on     = 1'b1;
    hold_results  = 1'b0;

    directed_rows = '{
      // both prefixes are zero after reset: the start prefix wins
      chk_byte(8'h00, EV_BUSY),
      chk_byte(8'h00, EV_ABORT),          // address byte is not 0xFF
      // write to the top address with a zero count, checksum follows the count
      any_byte(8'h00), any_byte(ADDR_BYTE), any_byte(CMD_WRITE),
      any_byte(8'hFF), any_byte(8'hFF), any_byte(8'hFF),
      chk_byte(8'h00, EV_BUSY),
      chk_byte(8'h00, EV_OK),
      cfg_row(CFG_START_PREFIX, 8'hA5),
      cfg_row(CFG_WAKEUP_PREFIX, 8'h5A),
      chk_byte(8'h33, EV_ABORT),          // unknown first byte while idle
      // wake-up read at address zero, full count, checksum off by one
      any_byte(8'h5A), any_byte(CMD_READ_B),
      any_byte(8'h00), any_byte(8'h00), any_byte(8'h00), any_byte(8'hFF),
      chk_byte(8'hF6, EV_CKERR),
      any_byte(8'hA5), any_byte(ADDR_BYTE),
      chk_byte(8'h0C, EV_ABORT),          // unknown command code
      any_byte(8'hA5), any_byte(ADDR_BYTE), any_byte(CMD_BOOT), any_byte(8'h66),
      chk_byte(8'h00, EV_ABORT)           // wrong boot key byte
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      if (directed_rows[k].kind == ROW_CFG) begin
        finish_stream();
        write_reg(directed_rows[k].idx, directed_rows[k].value);
      end else begin
        send_byte(directed_rows[k].value, directed_rows[k].pinned, directed_rows[k].ev);
      end
    end
    finish_stream();

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       {s_val, w_val} = {8'h00, 8'hFF};
        1:       {s_val, w_val} = {8'hFF, 8'h00};
        2:       {s_val, w_val} = {8'h3C, 8'h3C};   // equal prefixes
        default: {s_val, w_val} = {8'($urandom), 8'($urandom)};
      endcase
      write_reg(CFG_START_PREFIX, s_val);
      write_reg(CFG_WAKEUP_PREFIX, w_val);
      // last phase runs at full rate on both sides
      idling_on = (phase != NUM_PHASES - 1);
      // hold off events while bytes keep coming, so the input stalls
      if (phase == 1) hold_results = 1'b1;
      run_traffic(PHASE_ITEMS);
      finish_stream();
    end

    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
